>>> src/fsfd_pkg.sv
// Shared types and constants for the fire sensor fusion decider.
package fsfd_pkg;

	localparam int NumCh     = 5;
	localparam int CountBits = 16;
	localparam logic [14:0] FullScore = 15'd25600;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_FIRE    = 2'd1,
		EV_RECOVER = 2'd2
	} event_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RAMP,
		ST_SUM,
		ST_DIV,
		ST_DECIDE,
		ST_OUT
	} state_t;

	localparam logic [2:0] REG_GAS    = 3'd0;
	localparam logic [2:0] REG_SPARK  = 3'd1;
	localparam logic [2:0] REG_TEMP   = 3'd2;
	localparam logic [2:0] REG_HUMI   = 3'd3;
	localparam logic [2:0] REG_IRTEMP = 3'd4;
	localparam logic [2:0] REG_WEIGHT = 3'd5;
	localparam logic [2:0] REG_LIMITS = 3'd6;
	localparam logic [2:0] REG_COUNTS = 3'd7;

	// Divider request and reply between the top level and the serial divider.
	typedef struct packed {
		logic        start;
		logic [30:0] num;
		logic [16:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [30:0] quo;
	} div_rsp_t;

endpackage

>>> src/fsfd_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module fsfd_div
	import fsfd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [30:0] quo_q;
	logic [17:0] rem_q;
	logic [16:0] den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [17:0] trial;

	assign trial = {rem_q[16:0], quo_q[30]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd30;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[29:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[29:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(busy_q))
		else $error("divider done without a run");

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(req.start))
		else $error("divider started without request");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("divider done held");

endmodule

>>> src/fire_sensor_fusion_decider.sv
// Fire sensor fusion decider: ramp scoring, weighted fusion and fire state control.
// A scored report passes ST_DECIDE, five ramp steps (each settled at once or by a 31-bit serial
// division), five sum steps, the composite division and ST_OUT; a recover command or frozen
// report goes from ST_DECIDE straight to ST_OUT. One item is handled at a time; the next is
// taken in the cycle after the result beat leaves.
// Reset: arst_n clears the state machine, counters, fire state, configuration and working registers to zero.
module fire_sensor_fusion_decider
	import fsfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [11:0] gas_level,
	input  logic [11:0] spark_level,
	input  logic signed [11:0] air_temp,
	input  logic [10:0] rel_humidity,
	input  logic signed [13:0] surface_temp,
	input  logic        gas_ok,
	input  logic        spark_ok,
	input  logic        climate_ok,
	input  logic        surface_ok,
	input  logic [31:0] report_seq,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_res,
	output logic        zone_fire,
	output logic [2:0]  cause,
	output logic [31:0] trigger_seq,
	output logic [14:0] composite,
	output logic        composite_valid,
	output logic [15:0] freeze_count,
	output logic        recover_ready
);

	localparam logic [CountBits-1:0] CntMax = '1;

	logic [23:0] gas_b_q, spark_b_q;
	logic [31:0] temp_b_q, humi_b_q, ir_b_q;
	logic [59:0] wgt_q;
	logic [63:0] lim_q;
	logic [47:0] cnt_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gas_b_q <= '0; spark_b_q <= '0; temp_b_q <= '0; humi_b_q <= '0;
			ir_b_q <= '0; wgt_q <= '0; lim_q <= '0; cnt_cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAS:    gas_b_q   <= cfg_data[23:0];
				REG_SPARK:  spark_b_q <= cfg_data[23:0];
				REG_TEMP:   temp_b_q  <= cfg_data[31:0];
				REG_HUMI:   humi_b_q  <= cfg_data[31:0];
				REG_IRTEMP: ir_b_q    <= cfg_data[31:0];
				REG_WEIGHT: wgt_q     <= cfg_data[59:0];
				REG_LIMITS: lim_q     <= cfg_data;
				REG_COUNTS: cnt_cfg_q <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	// captured item
	logic        func_q;
	logic [11:0] gas_lv_q, spark_lv_q;
	logic signed [11:0] air_q;
	logic [10:0] humi_lv_q;
	logic signed [13:0] surf_q;
	logic [4:0]  ok_q;
	logic [31:0] seq_q;

	// decision state
	logic                 fire_q, relaxed_q;
	logic [CountBits-1:0] conf_q, clear_q, frozen_q;
	logic [2:0]           cause_q;
	logic [31:0]          fseq_q;

	// working registers
	state_t      st_q, st_d;
	logic [2:0]  ch_q;
	logic [14:0] sc_q [NumCh];
	logic [28:0] acc_q;
	logic [14:0] comp_q;
	logic        cvalid_q;
	logic        div_wait_q;
	logic [1:0]  ev_q;

	div_req_t dreq;
	div_rsp_t drsp;

	fsfd_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// ramp of channel ch_q on the captured item
	logic signed [17:0] rv, rlo, rhi, rdist, rspan;
	logic               rdown;
	always_comb begin
		rdown = 1'b0;
		rv = '0; rlo = '0; rhi = '0;
		unique case (ch_q)
			3'd0: begin
				rv = {6'd0, gas_lv_q}; rlo = {6'd0, gas_b_q[11:0]};
				rhi = {6'd0, gas_b_q[23:12]};
			end
			3'd1: begin
				rdown = 1'b1; rv = {6'd0, spark_lv_q};
				rlo = {6'd0, spark_b_q[11:0]}; rhi = {6'd0, spark_b_q[23:12]};
			end
			3'd2: begin
				rv = 18'(air_q); rlo = 18'(signed'(temp_b_q[15:0]));
				rhi = 18'(signed'(temp_b_q[31:16]));
			end
			3'd3: begin
				rdown = 1'b1; rv = {7'd0, humi_lv_q};
				rlo = {2'd0, humi_b_q[15:0]}; rhi = {2'd0, humi_b_q[31:16]};
			end
			3'd4: begin
				rv = 18'(surf_q); rlo = 18'(signed'(ir_b_q[15:0]));
				rhi = 18'(signed'(ir_b_q[31:16]));
			end
			default: ;
		endcase
		rdist = rdown ? rlo - rv : rv - rlo;
		rspan = rdown ? rlo - rhi : rhi - rlo;
	end
	logic r_zero, r_full;
	assign r_zero = rdown ? (rv >= rlo) : (rv <= rlo);
	assign r_full = rdown ? (rv <= rhi) : (rv >= rhi);

	logic [4:0] ok_in;
	assign ok_in = {surface_ok, climate_ok, climate_ok, spark_ok, gas_ok};

	logic [11:0] w_ch;
	assign w_ch = wgt_q[12*ch_q +: 12];

	// valid weight total and surviving weight (same thing)
	logic [14:0] wsum;
	always_comb begin
		wsum = '0;
		for (int i = 0; i < NumCh; i++)
			if (ok_q[i]) wsum = wsum + 15'(wgt_q[12*i +: 12]);
	end
	logic [16:0] wden;
	assign wden = ({2'd0, wsum} < {1'b0, lim_q[63:48]}) ? {1'b0, lim_q[63:48]}
	                                                   : {2'd0, wsum};

	// cause pick, one channel per sum step
	logic [26:0] best_p_q;
	logic [2:0]  best_q;

	// one 15x12 product per sum step
	logic [26:0] prod_now;
	assign prod_now = 27'(sc_q[ch_q]) * 27'(w_ch);

	logic accept;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (st_q != ST_IDLE);

	// channel finished this cycle: settled at once, or its division has come back
	logic ch_done, div_fin;
	assign ch_done = div_wait_q ? drsp.done : (r_zero || r_full || !ok_q[ch_q]);
	assign div_fin = div_wait_q ? drsp.done : (wden == '0);

	// freeze handling in FIRE: scoring goes ahead unless frozen
	logic [CountBits-1:0] frz_inc;
	logic                 go_now;
	assign frz_inc = (frozen_q == CntMax) ? frozen_q : frozen_q + 1'b1;
	assign go_now  = (&ok_q)
	              || !(frz_inc < cnt_cfg_q[47:32] || {1'b0, wsum} < lim_q[63:48]);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:   if (accept) st_d = ST_DECIDE;
			ST_RAMP:   if (ch_q == 3'(NumCh - 1) && ch_done) st_d = ST_SUM;
			ST_SUM:    if (ch_q == 3'(NumCh - 1)) st_d = ST_DIV;
			ST_DIV:    if (div_fin) st_d = ST_OUT;
			ST_DECIDE: st_d = (!func_q && (!fire_q || go_now)) ? ST_RAMP : ST_OUT;
			ST_OUT:    if (!out_stall) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	// ST_DECIDE is the pre-step (recover command and freeze handling); the final decision is taken on
	// leaving ST_DIV.
	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = '0;
		dreq.den   = '0;
		if (st_q == ST_RAMP && !div_wait_q && ok_q[ch_q] && !r_zero && !r_full) begin
			dreq.start = 1'b1;
			dreq.num   = 31'(rdist[16:0]) * 31'(FullScore);
			dreq.den   = rspan[16:0];
		end else if (st_q == ST_DIV && !div_wait_q && wden != '0) begin
			dreq.start = 1'b1;
			dreq.num   = {2'd0, acc_q};
			dreq.den   = wden;
		end
	end

	logic        isf;
	logic [14:0] comp_n;
	assign comp_n = (wden == '0) ? '0 : drsp.quo[14:0];
	assign isf = ({1'b0, sc_q[1]} >= lim_q[31:16] && {1'b0, sc_q[4]} >= lim_q[47:32])
	          || ({1'b0, comp_n} >= lim_q[15:0]);

	logic [CountBits-1:0] conf_inc, conf_nx, clear_nx;
	assign conf_inc = (conf_q == CntMax) ? conf_q : conf_q + 1'b1;
	assign conf_nx  = isf ? conf_inc : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; ch_q <= '0; div_wait_q <= 1'b0;
			fire_q <= 1'b0; relaxed_q <= 1'b0; conf_q <= '0; clear_q <= '0;
			frozen_q <= '0; cause_q <= '0; fseq_q <= '0; ev_q <= EV_NONE;
			comp_q <= '0; cvalid_q <= 1'b0; acc_q <= '0;
			best_p_q <= '0; best_q <= '0;
			for (int i = 0; i < NumCh; i++) sc_q[i] <= '0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				ST_IDLE: if (accept) begin
					ev_q <= EV_NONE; comp_q <= '0; cvalid_q <= 1'b0;
				end
				ST_DECIDE: begin
					ch_q <= '0; div_wait_q <= 1'b0; acc_q <= '0;
					if (func_q) begin
						if (fire_q) begin
							fire_q <= 1'b0; clear_q <= '0; frozen_q <= '0;
							relaxed_q <= 1'b0; ev_q <= EV_RECOVER;
						end
					end else if (fire_q) begin
						if (&ok_q) begin
							frozen_q <= '0; relaxed_q <= 1'b0;
						end else begin
							frozen_q <= frz_inc;
							if (go_now && !relaxed_q) begin
								relaxed_q <= 1'b1; clear_q <= '0;
							end
						end
					end
				end
				ST_RAMP: begin
					if (!div_wait_q) begin
						if (r_zero || r_full || !ok_q[ch_q]) begin
							sc_q[ch_q] <= (!ok_q[ch_q] || r_zero) ? '0 : FullScore;
							if (ch_q != 3'(NumCh - 1)) ch_q <= ch_q + 1'b1;
							else ch_q <= '0;
						end else div_wait_q <= 1'b1;
					end else if (drsp.done) begin
						sc_q[ch_q] <= drsp.quo[14:0];
						div_wait_q <= 1'b0;
						ch_q <= (ch_q != 3'(NumCh - 1)) ? ch_q + 1'b1 : '0;
					end
					best_p_q <= '0; best_q <= '0;
				end
				ST_SUM: begin
					if (ch_q == 3'd0 || prod_now > best_p_q) begin
						best_p_q <= prod_now; best_q <= ch_q;
					end
					acc_q <= acc_q + 29'(prod_now);
					ch_q <= (ch_q != 3'(NumCh - 1)) ? ch_q + 1'b1 : '0;
				end
				ST_DIV: begin
					if (!div_wait_q && wden != '0) div_wait_q <= 1'b1;
					if (div_fin) begin
						div_wait_q <= 1'b0;
						comp_q <= comp_n; cvalid_q <= 1'b1;
						if (!fire_q) begin
							if (conf_nx >= cnt_cfg_q[15:0]) begin
								cause_q <= best_q + 3'd1; fire_q <= 1'b1; fseq_q <= seq_q;
								conf_q <= '0; clear_q <= '0; frozen_q <= '0;
								relaxed_q <= 1'b0; ev_q <= EV_FIRE;
							end else conf_q <= conf_nx;
						end else begin
							clear_q <= clear_nx;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [CountBits:0] cn;
		cn = isf ? '0 : {1'b0, clear_q} + 1'b1;
		clear_nx = (cn > {1'b0, cnt_cfg_q[31:16]}) ? cnt_cfg_q[31:16] : cn[CountBits-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func; gas_lv_q <= gas_level; spark_lv_q <= spark_level;
			air_q <= air_temp; humi_lv_q <= rel_humidity; surf_q <= surface_temp;
			ok_q <= ok_in; seq_q <= report_seq;
		end
	end

	assign out_valid       = (st_q == ST_OUT);
	assign event_res       = ev_q;
	assign zone_fire       = fire_q;
	assign cause           = cause_q;
	assign trigger_seq     = fseq_q;
	assign composite       = comp_q;
	assign composite_valid = cvalid_q;
	assign freeze_count    = frozen_q;
	assign recover_ready   = fire_q && (clear_q >= cnt_cfg_q[31:16]);

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result waits");

	a_fire_event: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res == EV_FIRE) |-> zone_fire)
		else $error("fire event without fire state");

	a_rec_event: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res == EV_RECOVER) |-> !zone_fire && !composite_valid)
		else $error("recover result malformed");

	a_comp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> composite <= FullScore)
		else $error("composite out of range");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the fire sensor fusion decider.
`timescale 1ns / 100ps

class fusion_scoreboard;
	typedef struct packed {
		logic [1:0]  ev;
		logic        zone;
		logic [2:0]  cause;
		logic [31:0] tseq;
		logic [14:0] comp;
		logic        cvalid;
		logic [15:0] frz;
		logic        ready;
	} verdict_t;

	logic [63:0] regs [8];
	logic        fire_mode, relaxed;
	logic [15:0] confirm_hits, clear_hits, frozen;
	logic [2:0]  fire_cause;
	logic [31:0] last_seq;
	verdict_t    pending [$];
	int          errors;
	int          checked;
	int          fires;
	int          recovers;

	function void clear();
		for (int i = 0; i < 8; i++)
			regs[i] = '0;
		fire_mode = 0;
		relaxed = 0;
		confirm_hits = 0;
		clear_hits = 0;
		frozen = 0;
		fire_cause = 0;
		last_seq = 0;
		pending.delete();
		errors = 0;
		checked = 0;
		fires = 0;
		recovers = 0;
	endfunction

	function longint f16(int r, int k);
		return longint'(regs[r][16*k +: 16]);
	endfunction

	function longint sx16(int r, int k);
		return longint'($signed(regs[r][16*k +: 16]));
	endfunction

	function longint wgt(int i);
		return longint'(regs[fsfd_pkg::REG_WEIGHT][12*i +: 12]);
	endfunction

	function longint rise(longint v, longint lo, longint hi);
		if (v <= lo) return 0;
		if (v >= hi) return 25600;
		return (v - lo) * 25600 / (hi - lo);
	endfunction

	function longint fall(longint v, longint safe, longint danger);
		if (v >= safe) return 0;
		if (v <= danger) return 25600;
		return (safe - v) * 25600 / (safe - danger);
	endfunction

	function longint blend(logic [11:0] g, logic [11:0] s, logic signed [11:0] t,
			logic [10:0] h, logic signed [13:0] ir, logic [4:0] ok,
			output longint sc [5]);
		longint acc, wsum;
		acc = 0;
		wsum = 0;
		sc[0] = rise(g, regs[0][11:0], regs[0][23:12]);
		sc[1] = fall(s, regs[1][11:0], regs[1][23:12]);
		sc[2] = rise(longint'(t), sx16(2, 0), sx16(2, 1));
		sc[3] = fall(h, f16(3, 0), f16(3, 1));
		sc[4] = rise(longint'(ir), sx16(4, 0), sx16(4, 1));
		for (int i = 0; i < 5; i++) begin
			if (!ok[i]) begin
				sc[i] = 0;
				continue;
			end
			acc += sc[i] * wgt(i);
			wsum += wgt(i);
		end
		if (wsum < f16(6, 3)) wsum = f16(6, 3);
		if (wsum == 0) return 0;
		return acc / wsum;
	endfunction

	function bit fire_seen(longint comp, longint sc [5]);
		return (sc[1] >= f16(6, 1) && sc[4] >= f16(6, 2)) || comp >= f16(6, 0);
	endfunction

	function void note_item(logic fn, logic [11:0] g, logic [11:0] s,
			logic signed [11:0] t, logic [10:0] h, logic signed [13:0] ir,
			logic [4:0] ok, logic [31:0] rseq);
		verdict_t v;
		longint   sc [5];
		longint   comp, surv, nconf, nrec, relax;
		bit       go, all;
		int       best;
		v = '0;
		comp = 0;
		nconf = f16(7, 0);
		nrec = f16(7, 1);
		relax = f16(7, 2);
		if (fn) begin
			if (fire_mode) begin
				fire_mode = 0;
				clear_hits = 0;
				frozen = 0;
				relaxed = 0;
				v.ev = fsfd_pkg::EV_RECOVER;
				recovers++;
			end
		end else if (!fire_mode) begin
			comp = blend(g, s, t, h, ir, ok, sc);
			v.cvalid = 1;
			if (fire_seen(comp, sc)) begin
				if (confirm_hits != 16'hFFFF) confirm_hits++;
			end else
				confirm_hits = 0;
			if (confirm_hits >= nconf) begin
				best = 0;
				for (int i = 1; i < 5; i++)
					if (sc[i] * wgt(i) > sc[best] * wgt(best)) best = i;
				fire_cause = 3'(best + 1);
				fire_mode = 1;
				last_seq = rseq;
				confirm_hits = 0;
				clear_hits = 0;
				frozen = 0;
				relaxed = 0;
				v.ev = fsfd_pkg::EV_FIRE;
				fires++;
			end
		end else begin
			go = 1;
			all = &ok;
			surv = 0;
			for (int i = 0; i < 5; i++)
				if (ok[i]) surv += wgt(i);
			if (all) begin
				frozen = 0;
				relaxed = 0;
			end else begin
				if (frozen != 16'hFFFF) frozen++;
				if (frozen < relax || surv < f16(6, 3))
					go = 0;
				else if (!relaxed) begin
					relaxed = 1;
					clear_hits = 0;
				end
			end
			if (go) begin
				comp = blend(g, s, t, h, ir, ok, sc);
				v.cvalid = 1;
				// count up and clamp at the recover count without wrapping
				if (fire_seen(comp, sc)) clear_hits = 0;
				else if (clear_hits >= nrec) clear_hits = 16'(nrec);
				else clear_hits++;
			end
		end
		v.zone = fire_mode;
		v.cause = fire_cause;
		v.tseq = last_seq;
		v.comp = comp[14:0];
		v.frz = frozen;
		v.ready = fire_mode && clear_hits >= nrec;
		pending.push_back(v);
	endfunction

	task report(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d, want %0d (beat %0d)", what, got, want, checked);
		errors++;
	endtask

	task check_beat(verdict_t got);
		verdict_t w;
		checked++;
		if (pending.size() == 0) begin
			report("unexpected beat", 1, 0);
			return;
		end
		w = pending.pop_front();
		if (got.ev !== w.ev) report("event_res", got.ev, w.ev);
		if (got.zone !== w.zone) report("zone_fire", got.zone, w.zone);
		if (got.cause !== w.cause) report("cause", got.cause, w.cause);
		if (got.tseq !== w.tseq) report("trigger_seq", got.tseq, w.tseq);
		if (got.comp !== w.comp) report("composite", got.comp, w.comp);
		if (got.cvalid !== w.cvalid) report("composite_valid", got.cvalid, w.cvalid);
		if (got.frz !== w.frz) report("freeze_count", got.frz, w.frz);
		if (got.ready !== w.ready) report("recover_ready", got.ready, w.ready);
	endtask
endclass

module tb_top;
	import fsfd_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        func = 0;
	logic [11:0] gas_level = '0;
	logic [11:0] spark_level = '0;
	logic signed [11:0] air_temp = '0;
	logic [10:0] rel_humidity = '0;
	logic signed [13:0] surface_temp = '0;
	logic        gas_ok = 0, spark_ok = 0, climate_ok = 0, surface_ok = 0;
	logic [31:0] report_seq = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  event_res;
	logic        zone_fire;
	logic [2:0]  cause;
	logic [31:0] trigger_seq;
	logic [14:0] composite;
	logic        composite_valid;
	logic [15:0] freeze_count;
	logic        recover_ready;

	fusion_scoreboard board;
	bit          calm;
	int          stall_left;

	fire_sensor_fusion_decider u_top (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

	// result side: sample at the rising edge, stall bursts driven at the falling edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_beat({event_res, zone_fire, cause, trigger_seq, composite,
				composite_valid, freeze_count, recover_ready});
	end

	always @(negedge clk) begin
		if (calm || !arst_n)
			out_stall <= 0;
		else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 9);
			out_stall <= 1;
		end else
			out_stall <= 0;
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		board.regs[idx] = val;
	endtask

	task automatic drain();
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	// one beat: optional idle burst, then hold until taken
	task automatic send(logic fn, logic [11:0] g, logic [11:0] s, logic signed [11:0] t,
			logic [10:0] h, logic signed [13:0] ir, logic [4:0] ok, logic [31:0] rseq);
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 10)) @(negedge clk);
		in_valid <= 1;
		func <= fn;
		gas_level <= g;
		spark_level <= s;
		air_temp <= t;
		rel_humidity <= h;
		surface_temp <= ir;
		{surface_ok, climate_ok, spark_ok, gas_ok} <= {ok[4], ok[2], ok[1], ok[0]};
		report_seq <= rseq;
		do @(posedge clk); while (in_stall);
		board.note_item(fn, g, s, t, h, ir, {ok[4], ok[2], ok[2], ok[1], ok[0]}, rseq);
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic recover_cmd();
		send(1'b1, 12'd0, 12'd0, 12'sd0, 11'd0, 14'sd0, 5'd0, 32'd0);
	endtask

	task automatic rand_report(int okbias);
		logic [4:0] ok;
		ok = 5'b11111;
		if ($urandom_range(0, 99) < okbias) ok = 5'($urandom);
		ok[3] = ok[2];
		send($urandom_range(0, 15) == 0, 12'($urandom), 12'($urandom),
			$signed(12'($urandom_range(0, 2640))) - 12'sd640, 11'($urandom_range(0, 1600)),
			$signed(14'($urandom_range(0, 7200))) - 14'sd1120, ok, $urandom);
	endtask

	task automatic rand_setting();
		logic [63:0] v;
		write_reg(REG_GAS, 64'({12'($urandom_range(1000, 4095)),
			12'($urandom_range(0, 1500))}));
		write_reg(REG_SPARK, 64'({12'($urandom_range(0, 1500)),
			12'($urandom_range(1000, 4095))}));
		write_reg(REG_TEMP, 64'({16'($urandom_range(0, 2000)),
			16'($signed(-$urandom_range(0, 640)))}));
		write_reg(REG_HUMI, 64'({16'($urandom_range(0, 900)), 16'($urandom_range(500, 2047))}));
		write_reg(REG_IRTEMP, 64'({16'($urandom_range(0, 6080)),
			16'(-$urandom_range(0, 1120))}));
		v = {$urandom, $urandom};
		write_reg(REG_WEIGHT, 64'(v[59:0]));
		write_reg(REG_LIMITS, {16'($urandom_range(0, 3000)), 16'($urandom_range(0, 25600)),
			16'($urandom_range(0, 25600)), 16'($urandom_range(0, 25600))});
		write_reg(REG_COUNTS, 64'({16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
			16'($urandom_range(0, 4))}));
	endtask

	initial begin
		board = new();
		board.clear();
		calm = 0;
		stall_left = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: all-zero settings, then field extremes and special cases
		send(1'b0, 12'd0, 12'd0, 12'sd0, 11'd0, 14'sd0, 5'b11111, 32'h1);
		recover_cmd();
		recover_cmd();
		drain();
		write_reg(REG_GAS, 64'({12'd3000, 12'd1000}));
		write_reg(REG_SPARK, 64'({12'd500, 12'd3500}));
		write_reg(REG_TEMP, 64'({16'sd800, -16'sd100}));
		write_reg(REG_HUMI, 64'({16'd200, 16'd1200}));
		write_reg(REG_IRTEMP, 64'({16'sd4000, -16'sd200}));
		write_reg(REG_WEIGHT, 64'({12'd800, 12'd800, 12'd800, 12'd800, 12'd800}));
		write_reg(REG_LIMITS, {16'd1000, 16'd20000, 16'd20000, 16'd15000});
		write_reg(REG_COUNTS, 64'({16'd2, 16'd2, 16'd3}));
		send(1'b0, 12'd0, 12'hFFF, -12'sd640, 11'd1600, -14'sd1120, 5'b11111, 32'd10);
		send(1'b0, 12'hFFF, 12'd0, 12'sd2000, 11'd0, 14'sd6080, 5'b11111, 32'd11);
		send(1'b0, 12'hFFF, 12'd0, 12'sd2000, 11'd0, 14'sd6080, 5'b11111, 32'hFFFFFFFF);
		send(1'b0, 12'd2000, 12'd2000, 12'sd300, 11'd700, 14'sd1000, 5'b11111, 32'd13);
		send(1'b0, 12'd0, 12'hFFF, 12'sd0, 11'd1600, 14'sd0, 5'b00000, 32'd14);
		send(1'b0, 12'd0, 12'hFFF, 12'sd0, 11'd1600, 14'sd0, 5'b01111, 32'd15);
		send(1'b0, 12'd0, 12'hFFF, 12'sd0, 11'd1600, 14'sd0, 5'b10011, 32'd16);
		send(1'b0, 12'd0, 12'hFFF, 12'sd0, 11'd1600, 14'sd0, 5'b11110, 32'd17);
		send(1'b0, 12'd0, 12'hFFF, 12'sd0, 11'd1600, 14'sd0, 5'b11111, 32'd18);
		send(1'b0, 12'd0, 12'hFFF, 12'sd0, 11'd1600, 14'sd0, 5'b11111, 32'd19);
		recover_cmd();
		// reversed bounds, zero weights and zero minimum
		drain();
		write_reg(REG_GAS, 64'({12'd100, 12'd3000}));
		write_reg(REG_WEIGHT, '0);
		write_reg(REG_LIMITS, {16'd0, 16'd0, 16'd0, 16'd25600});
		write_reg(REG_COUNTS, 64'({16'd0, 16'hFFFF, 16'hFFFF}));
		send(1'b0, 12'd50, 12'd50, 12'sd0, 11'd0, 14'sd0, 5'b11111, 32'd20);
		send(1'b0, 12'd3100, 12'd50, 12'sd0, 11'd0, 14'sd0, 5'b10011, 32'd21);
		recover_cmd();
		// full weights and maximal limits
		drain();
		write_reg(REG_WEIGHT, 64'(60'hFFF_FFF_FFF_FFF_FFF));
		write_reg(REG_LIMITS, '1);
		write_reg(REG_COUNTS, 64'({16'd0, 16'd0, 16'd1}));
		send(1'b0, 12'hFFF, 12'd0, 12'sd2000, 11'd0, 14'sd6080, 5'b11111, 32'd30);
		send(1'b0, 12'hFFF, 12'd0, 12'sd2000, 11'd0, 14'sd6080, 5'b00100, 32'd31);
		recover_cmd();

		// random phases, each under a fresh setting
		for (int ph = 0; ph < 12; ph++) begin
			drain();
			rand_setting();
			if (ph >= 10) calm = 1;
			for (int n = 0; n < 95; n++)
				rand_report(ph % 3 == 0 ? 60 : 20);
		end
		drain();
		$display("Covered %0d beats, %0d fire declarations, %0d recoveries", board.checked,
			board.fires, board.recovers);
		$display("Settings: reset values, three directed sets and 12 random sets");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
